// ===== sv/usb_hid_pkg.sv =====
// Shared types, request codes and the descriptor ROM for the HID keyboard
// endpoint-0 responder. No dependencies; imported by every other file.
`default_nettype none
package usb_hid_pkg;

  typedef enum logic [1:0] {
    MODE_SETUP     = 2'd0,
    MODE_IN_DONE   = 2'd1,
    MODE_OUT_DONE  = 2'd2,
    MODE_BUS_RESET = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_ZLP   = 2'd1,
    KIND_STALL = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  localparam logic [7:0] REQ_SET_ADDRESS    = 8'h05;
  localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'h06;
  localparam logic [7:0] REQ_SET_CONFIG     = 8'h09;
  localparam logic [7:0] REQ_SET_IDLE       = 8'h0A;
  localparam logic [7:0] RTYPE_CLASS_IFACE  = 8'h21;

  localparam logic [7:0] DT_DEVICE = 8'h01;
  localparam logic [7:0] DT_CONFIG = 8'h02;
  localparam logic [7:0] DT_STRING = 8'h03;
  localparam logic [7:0] DT_REPORT = 8'h22;

  localparam int ADDR_W  = 7;
  localparam int COUNT_W = 6;
  localparam int ROM_AW  = 8;
  localparam int ROM_DEPTH = 169;

  // Descriptor sizes in bytes
  localparam logic [COUNT_W-1:0] SZ_DEVICE  = 6'd18;
  localparam logic [COUNT_W-1:0] SZ_CONFIG  = 6'd34;
  localparam logic [COUNT_W-1:0] SZ_REPORT  = 6'd63;
  localparam logic [COUNT_W-1:0] SZ_LANG    = 6'd4;
  localparam logic [COUNT_W-1:0] SZ_MAKER   = 6'd14;
  localparam logic [COUNT_W-1:0] SZ_PRODUCT = 6'd36;

  // Start offsets of each descriptor in the packed ROM
  localparam logic [ROM_AW-1:0] BASE_DEVICE  = 8'd0;
  localparam logic [ROM_AW-1:0] BASE_CONFIG  = 8'd18;
  localparam logic [ROM_AW-1:0] BASE_REPORT  = 8'd52;
  localparam logic [ROM_AW-1:0] BASE_LANG    = 8'd115;
  localparam logic [ROM_AW-1:0] BASE_MAKER   = 8'd119;
  localparam logic [ROM_AW-1:0] BASE_PRODUCT = 8'd133;

  localparam logic [7:0] DESC_ROM [ROM_DEPTH] = '{
    // device
    8'h12, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h40,
    8'h83, 8'h04, 8'h22, 8'h22, 8'h00, 8'h02, 8'h01, 8'h02,
    8'h00, 8'h01,
    // configuration, interface, HID, endpoint
    8'h09, 8'h02, 8'h22, 8'h00, 8'h01, 8'h01, 8'h00, 8'hE0, 8'h32,
    8'h09, 8'h04, 8'h00, 8'h00, 8'h01, 8'h03, 8'h01, 8'h01, 8'h00,
    8'h09, 8'h21, 8'h11, 8'h01, 8'h00, 8'h01, 8'h22, 8'h3F, 8'h00,
    8'h07, 8'h05, 8'h81, 8'h03, 8'h08, 8'h00, 8'h0A,
    // report
    8'h05, 8'h01, 8'h09, 8'h06, 8'hA1, 8'h01, 8'h05, 8'h07, 8'h19, 8'hE0,
    8'h29, 8'hE7, 8'h15, 8'h00, 8'h25, 8'h01, 8'h75, 8'h01, 8'h95, 8'h08,
    8'h81, 8'h02, 8'h95, 8'h01, 8'h75, 8'h08, 8'h81, 8'h03, 8'h95, 8'h05,
    8'h75, 8'h01, 8'h05, 8'h08, 8'h19, 8'h01, 8'h29, 8'h05, 8'h91, 8'h02,
    8'h95, 8'h01, 8'h75, 8'h03, 8'h91, 8'h03, 8'h95, 8'h06, 8'h75, 8'h08,
    8'h15, 8'h00, 8'h25, 8'h65, 8'h05, 8'h07, 8'h19, 8'h00, 8'h29, 8'h65,
    8'h81, 8'h00, 8'hC0,
    // string 0: language IDs
    8'h04, 8'h03, 8'h09, 8'h04,
    // string 1: manufacturer
    8'h0E, 8'h03, 8'h72, 8'h00, 8'h69, 8'h00, 8'h63, 8'h00,
    8'h68, 8'h00, 8'h61, 8'h00, 8'h64, 8'h00,
    // string 2: product
    8'h24, 8'h03, 8'h72, 8'h00, 8'h69, 8'h00, 8'h63, 8'h00,
    8'h68, 8'h00, 8'h61, 8'h00, 8'h64, 8'h00, 8'h27, 8'h00,
    8'h73, 8'h00, 8'h20, 8'h00, 8'h4B, 8'h00, 8'h65, 8'h00,
    8'h79, 8'h00, 8'h62, 8'h00, 8'h6F, 8'h00, 8'h61, 8'h00,
    8'h72, 8'h00, 8'h64, 8'h00
  };

  // What one accepted event asks the sequencer to do
  typedef struct packed {
    logic                  stream;     // emit descriptor bytes
    kind_t                 kind;       // reply when not streaming
    logic [ROM_AW-1:0]     base;
    logic [COUNT_W-1:0]    last_idx;
    logic                  set_pending;
    logic [ADDR_W-1:0]     pending_val;
    logic                  set_config;
    logic                  activate;
    logic                  clear_all;
  } plan_t;

endpackage
`default_nettype wire

// ===== sv/usb_hid_control_request_responder.sv =====
// Endpoint-0 responder for a HID keyboard; one event per input transfer.
// The accepted event is registered as a plan; its first result is then loaded into the output register.
// Descriptor replies give one byte per cycle while the output is not stalled, from a shared ROM
// read port under a byte counter, up to 63 bytes per reply; other events give a single result.
// Input is held off until the last result is loaded.
// Reset (rst, synchronous): address, pending address, configuration clear.
`default_nettype none
module usb_hid_control_request_responder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [1:0]  mode,
  input  wire logic [7:0]  request_type,
  input  wire logic [7:0]  request_code,
  input  wire logic [15:0] request_value,
  input  wire logic [15:0] request_length,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [1:0]  reply_kind,
  output      logic [7:0]  data_byte,
  output      logic        last,
  output      logic [6:0]  device_address,
  output      logic        configured
);
  import usb_hid_pkg::*;

  plan_t              plan;
  state_t             state, state_next;
  logic [ADDR_W-1:0]  pending_address;
  logic [ADDR_W-1:0]  active_address;
  logic               config_done;
  logic               run_stream;
  kind_t              run_kind;
  logic [ROM_AW-1:0]  run_base;
  logic [COUNT_W-1:0] run_last;
  logic [COUNT_W-1:0] idx;
  logic               out_valid_next;
  logic               accept;
  logic               load;
  logic               final_item;
  logic [ROM_AW-1:0]  rom_addr;
  kind_t              out_kind;

  usb_hid_decode u_decode (
    .mode           (mode),
    .request_type   (request_type),
    .request_code   (request_code),
    .request_value  (request_value),
    .request_length (request_length),
    .plan           (plan)
  );

  assign accept     = in_valid && in_ready;
  assign final_item = !run_stream || (idx == run_last);
  assign rom_addr   = run_base + {2'b00, idx};

  always_comb begin
    state_next     = state;
    in_ready       = (state == ST_IDLE);
    out_valid_next = out_valid && !out_ready;
    load           = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        // Fill the output register whenever it is free
        if (!out_valid || out_ready) begin
          load           = 1'b1;
          out_valid_next = 1'b1;
          if (final_item) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      out_valid       <= 1'b0;
      pending_address <= '0;
      active_address  <= '0;
      config_done     <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      if (accept) begin
        if (plan.clear_all) begin
          pending_address <= '0;
          active_address  <= '0;
          config_done     <= 1'b0;
        end
        if (plan.activate && pending_address != '0) begin
          active_address  <= pending_address;
          pending_address <= '0;
        end
        if (plan.set_pending) begin
          pending_address <= plan.pending_val;
        end
        if (plan.set_config) begin
          config_done <= 1'b1;
        end
      end
    end
  end

  // Plan and output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      run_stream <= plan.stream;
      run_kind   <= plan.kind;
      run_base   <= plan.base;
      run_last   <= plan.last_idx;
      idx        <= '0;
    end else if (load) begin
      idx <= idx + 6'd1;
    end
    if (load) begin
      out_kind       <= run_kind;
      data_byte      <= run_stream ? DESC_ROM[rom_addr] : 8'h00;
      last           <= final_item;
      device_address <= active_address;
      configured     <= config_done;
    end
  end

  assign reply_kind = out_kind;

endmodule
`default_nettype wire

// ===== sv/usb_hid_decode.sv =====
// Decodes one bus event (setup packet or completion) into a plan for the
// sequencer: reply kind, descriptor window and state effects. Uses usb_hid_pkg.
`default_nettype none
module usb_hid_decode (
  input  wire logic [1:0]        mode,
  input  wire logic [7:0]        request_type,
  input  wire logic [7:0]        request_code,
  input  wire logic [15:0]       request_value,
  input  wire logic [15:0]       request_length,
  output usb_hid_pkg::plan_t     plan
);
  import usb_hid_pkg::*;

  logic [7:0]         dtype;
  logic [7:0]         dindex;
  logic               desc_ok;
  logic               clip;
  logic [COUNT_W-1:0] size;
  logic [ROM_AW-1:0]  base;
  logic [COUNT_W-1:0] count;

  assign dtype  = request_value[15:8];
  assign dindex = request_value[7:0];

  // Descriptor lookup
  always_comb begin
    desc_ok = 1'b1;
    clip    = 1'b1;
    size    = SZ_DEVICE;
    base    = BASE_DEVICE;
    priority if (dtype == DT_DEVICE) begin
      clip = 1'b0;
    end else if (dtype == DT_CONFIG) begin
      size = SZ_CONFIG;
      base = BASE_CONFIG;
    end else if (dtype == DT_REPORT) begin
      size = SZ_REPORT;
      base = BASE_REPORT;
    end else if (dtype == DT_STRING && dindex == 8'd0) begin
      size = SZ_LANG;
      base = BASE_LANG;
    end else if (dtype == DT_STRING && dindex == 8'd1) begin
      size = SZ_MAKER;
      base = BASE_MAKER;
    end else if (dtype == DT_STRING && dindex == 8'd2) begin
      size = SZ_PRODUCT;
      base = BASE_PRODUCT;
    end else begin
      desc_ok = 1'b0;
    end
  end

  // Clip to wLength except for the device descriptor
  assign count = (clip && (request_length < {10'd0, size})) ? request_length[COUNT_W-1:0]
                                                             : size;

  always_comb begin
    plan             = '0;
    plan.kind        = KIND_NONE;
    plan.base        = base;
    plan.last_idx    = count - 6'd1;
    plan.pending_val = request_value[ADDR_W-1:0];
    unique case (mode_t'(mode))
      MODE_BUS_RESET: plan.clear_all = 1'b1;
      MODE_IN_DONE:   plan.activate  = 1'b1;
      MODE_OUT_DONE:  plan.kind      = KIND_NONE;
      MODE_SETUP: begin
        priority if (request_code == REQ_GET_DESCRIPTOR) begin
          priority if (!desc_ok) begin
            plan.kind = KIND_STALL;
          end else if (count == '0) begin
            plan.kind = KIND_ZLP;
          end else begin
            plan.stream = 1'b1;
            plan.kind   = KIND_DATA;
          end
        end else if (request_code == REQ_SET_ADDRESS) begin
          plan.set_pending = 1'b1;
          plan.kind        = KIND_ZLP;
        end else if (request_code == REQ_SET_CONFIG) begin
          plan.set_config = 1'b1;
          plan.kind       = KIND_ZLP;
        end else if (request_type == RTYPE_CLASS_IFACE && request_code == REQ_SET_IDLE) begin
          plan.kind = KIND_ZLP;
        end else begin
          plan.kind = KIND_STALL;
        end
      end
      default: plan.kind = KIND_NONE;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/usb_hid_checker.sv =====
// Port-level checks for the HID endpoint-0 responder, bound to the top level.
// Uses usb_hid_pkg for reply codes.
`default_nettype none
module usb_hid_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] reply_kind,
  input wire logic [7:0] data_byte,
  input wire logic       last
);
  import usb_hid_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(last))
    else $error("result changed while stalled");

  // No new event while a reply is mid-stream
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("input taken during a multi-byte reply");

  // Non-data replies are single results with a zero byte
  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && reply_kind != KIND_DATA |-> last && data_byte == 8'h00)
    else $error("non-data reply malformed");

  // Descriptor bytes follow without gaps
  a_stream: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid && reply_kind == KIND_DATA)
    else $error("gap in descriptor stream");

endmodule

bind usb_hid_control_request_responder usb_hid_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .reply_kind (reply_kind),
  .data_byte  (data_byte),
  .last       (last)
);
`default_nettype wire

// ===== tb/usb_hid_control_request_responder_tb.sv =====
// Self-checking testbench for the HID keyboard endpoint-0 responder.
// Drives bus events over valid/ready, predicts every reply byte and status
// from its own descriptor tables, and checks them in order. Needs usb_hid_pkg.
`default_nettype none
module usb_hid_control_request_responder_tb;
  import usb_hid_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 8;

  // Descriptor images, packed back to back
  localparam int OFS_DEVICE  = 0;
  localparam int OFS_CONFIG  = 18;
  localparam int OFS_REPORT  = 52;
  localparam int OFS_LANG    = 115;
  localparam int OFS_MAKER   = 119;
  localparam int OFS_PRODUCT = 133;

  localparam logic [7:0] DESC_BYTES [169] = '{
    8'h12, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h40,
    8'h83, 8'h04, 8'h22, 8'h22, 8'h00, 8'h02, 8'h01, 8'h02,
    8'h00, 8'h01,
    8'h09, 8'h02, 8'h22, 8'h00, 8'h01, 8'h01, 8'h00, 8'hE0, 8'h32,
    8'h09, 8'h04, 8'h00, 8'h00, 8'h01, 8'h03, 8'h01, 8'h01, 8'h00,
    8'h09, 8'h21, 8'h11, 8'h01, 8'h00, 8'h01, 8'h22, 8'h3F, 8'h00,
    8'h07, 8'h05, 8'h81, 8'h03, 8'h08, 8'h00, 8'h0A,
    8'h05, 8'h01, 8'h09, 8'h06, 8'hA1, 8'h01, 8'h05, 8'h07, 8'h19, 8'hE0,
    8'h29, 8'hE7, 8'h15, 8'h00, 8'h25, 8'h01, 8'h75, 8'h01, 8'h95, 8'h08,
    8'h81, 8'h02, 8'h95, 8'h01, 8'h75, 8'h08, 8'h81, 8'h03, 8'h95, 8'h05,
    8'h75, 8'h01, 8'h05, 8'h08, 8'h19, 8'h01, 8'h29, 8'h05, 8'h91, 8'h02,
    8'h95, 8'h01, 8'h75, 8'h03, 8'h91, 8'h03, 8'h95, 8'h06, 8'h75, 8'h08,
    8'h15, 8'h00, 8'h25, 8'h65, 8'h05, 8'h07, 8'h19, 8'h00, 8'h29, 8'h65,
    8'h81, 8'h00, 8'hC0,
    8'h04, 8'h03, 8'h09, 8'h04,
    8'h0E, 8'h03, 8'h72, 8'h00, 8'h69, 8'h00, 8'h63, 8'h00,
    8'h68, 8'h00, 8'h61, 8'h00, 8'h64, 8'h00,
    8'h24, 8'h03, 8'h72, 8'h00, 8'h69, 8'h00, 8'h63, 8'h00,
    8'h68, 8'h00, 8'h61, 8'h00, 8'h64, 8'h00, 8'h27, 8'h00,
    8'h73, 8'h00, 8'h20, 8'h00, 8'h4B, 8'h00, 8'h65, 8'h00,
    8'h79, 8'h00, 8'h62, 8'h00, 8'h6F, 8'h00, 8'h61, 8'h00,
    8'h72, 8'h00, 8'h64, 8'h00
  };

  typedef struct {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
    logic [6:0] addr;
    logic       armed;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  mode = '0;
  logic [7:0]  request_type = '0;
  logic [7:0]  request_code = '0;
  logic [15:0] request_value = '0;
  logic [15:0] request_length = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  reply_kind;
  logic [7:0]  data_byte;
  logic        last;
  logic [6:0]  device_address;
  logic        configured;

  reply_t     expected_replies[$];
  logic [6:0] model_pending = '0;
  logic [6:0] model_address = '0;
  logic       model_armed = 1'b0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         error_count = 0;
  int         cycle_count = 0;

  usb_hid_control_request_responder dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .request_type(request_type), .request_code(request_code),
    .request_value(request_value), .request_length(request_length),
    .out_valid(out_valid), .out_ready(out_ready),
    .reply_kind(reply_kind), .data_byte(data_byte), .last(last),
    .device_address(device_address), .configured(configured)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[usb_hid_control_request_responder] ERROR");
      $finish;
    end
  end

  // ---------------- prediction ----------------

  task automatic push_reply(kind_t k, logic [7:0] b, logic is_last);
    reply_t r;
    r.kind  = k;
    r.data  = b;
    r.last  = is_last;
    r.addr  = model_address;
    r.armed = model_armed;
    expected_replies.push_back(r);
  endtask

  task automatic push_descriptor(int base, int size, int limit);
    int n;
    n = (limit < size) ? limit : size;
    if (n == 0) begin
      push_reply(KIND_ZLP, 8'h00, 1'b1);
    end else begin
      for (int i = 0; i < n; i++)
        push_reply(KIND_DATA, DESC_BYTES[base + i], i == n - 1);
    end
  endtask

  task automatic predict_replies(mode_t m, logic [7:0] rt, logic [7:0] rc,
                                 logic [15:0] rv, logic [15:0] rl);
    case (m)
      MODE_BUS_RESET: begin
        model_pending = '0;
        model_address = '0;
        model_armed   = 1'b0;
        push_reply(KIND_NONE, 8'h00, 1'b1);
      end
      MODE_IN_DONE: begin
        if (model_pending != '0) begin
          model_address = model_pending;
          model_pending = '0;
        end
        push_reply(KIND_NONE, 8'h00, 1'b1);
      end
      MODE_OUT_DONE: push_reply(KIND_NONE, 8'h00, 1'b1);
      default: begin
        if (rc == REQ_GET_DESCRIPTOR) begin
          case (rv[15:8])
            DT_DEVICE: push_descriptor(OFS_DEVICE, 18, 18);
            DT_CONFIG: push_descriptor(OFS_CONFIG, 34, int'(rl));
            DT_REPORT: push_descriptor(OFS_REPORT, 63, int'(rl));
            DT_STRING: begin
              case (rv[7:0])
                8'd0: push_descriptor(OFS_LANG, 4, int'(rl));
                8'd1: push_descriptor(OFS_MAKER, 14, int'(rl));
                8'd2: push_descriptor(OFS_PRODUCT, 36, int'(rl));
                default: push_reply(KIND_STALL, 8'h00, 1'b1);
              endcase
            end
            default: push_reply(KIND_STALL, 8'h00, 1'b1);
          endcase
        end else if (rc == REQ_SET_ADDRESS) begin
          model_pending = rv[6:0];
          push_reply(KIND_ZLP, 8'h00, 1'b1);
        end else if (rc == REQ_SET_CONFIG) begin
          model_armed = 1'b1;
          push_reply(KIND_ZLP, 8'h00, 1'b1);
        end else if (rt == RTYPE_CLASS_IFACE && rc == REQ_SET_IDLE) begin
          push_reply(KIND_ZLP, 8'h00, 1'b1);
        end else begin
          push_reply(KIND_STALL, 8'h00, 1'b1);
        end
      end
    endcase
  endtask

  // ---------------- stimulus ----------------

  // Called right after a rising edge; returns at the edge that takes the transfer.
  task automatic send_event(mode_t m, logic [7:0] rt, logic [7:0] rc,
                            logic [15:0] rv, logic [15:0] rl);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    mode           <= m;
    request_type   <= rt;
    request_code   <= rc;
    request_value  <= rv;
    request_length <= rl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_replies(m, rt, rc, rv, rl);
  endtask

  task automatic get_descriptor(logic [7:0] rt, logic [7:0] dtype, logic [7:0] idx,
                                logic [15:0] len);
    send_event(MODE_SETUP, rt, REQ_GET_DESCRIPTOR, {dtype, idx}, len);
  endtask

  task automatic test_descriptor_reads();
    get_descriptor(8'h80, DT_DEVICE, 8'h00, 16'd0);
    get_descriptor(8'hFF, DT_DEVICE, 8'hFF, 16'hFFFF);
    get_descriptor(8'h80, DT_CONFIG, 8'h00, 16'd0);
    get_descriptor(8'h80, DT_CONFIG, 8'h00, 16'd1);
    get_descriptor(8'h00, DT_CONFIG, 8'h00, 16'hFFFF);
    get_descriptor(8'h81, DT_REPORT, 8'h00, 16'd62);
    get_descriptor(8'h00, DT_REPORT, 8'h00, 16'd63);
    get_descriptor(8'h80, DT_STRING, 8'd0, 16'hFFFF);
    get_descriptor(8'h80, DT_STRING, 8'd1, 16'd13);
    get_descriptor(8'h80, DT_STRING, 8'd2, 16'd36);
    get_descriptor(8'h80, DT_STRING, 8'd3, 16'd255);
    get_descriptor(8'h80, 8'hFF, 8'h00, 16'd64);
    get_descriptor(8'h80, 8'h00, 8'h00, 16'd64);
  endtask

  task automatic test_address_and_config();
    send_event(MODE_SETUP, 8'h00, REQ_SET_ADDRESS, 16'hFF7F, 16'hFFFF);
    send_event(MODE_OUT_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000);
    send_event(MODE_IN_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000);
    // address zero leaves the live address alone
    send_event(MODE_SETUP, 8'hFF, REQ_SET_ADDRESS, 16'hFF00, 16'd0);
    send_event(MODE_IN_DONE, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_event(MODE_SETUP, 8'h00, REQ_SET_CONFIG, 16'h0001, 16'd0);
    send_event(MODE_SETUP, RTYPE_CLASS_IFACE, REQ_SET_IDLE, 16'h0000, 16'd0);
    send_event(MODE_SETUP, 8'hA1, REQ_SET_IDLE, 16'h0000, 16'd0);
    send_event(MODE_SETUP, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_event(MODE_SETUP, 8'h00, 8'h00, 16'h0000, 16'h0000);
    send_event(MODE_BUS_RESET, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
  endtask

  function automatic logic [15:0] pick_length();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 70));
  endfunction

  task automatic test_random_traffic(int count);
    int pick;
    logic [7:0] rt;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 13);
      rt   = 8'($urandom);
      case (pick)
        0: get_descriptor(rt, DT_DEVICE, 8'($urandom), 16'($urandom));
        1, 2: get_descriptor(rt, DT_CONFIG, 8'($urandom), pick_length());
        3: get_descriptor(rt, DT_REPORT, 8'($urandom), pick_length());
        4: get_descriptor(rt, DT_STRING, 8'($urandom_range(0, 3)), pick_length());
        5: send_event(MODE_SETUP, rt, REQ_SET_ADDRESS, 16'($urandom), 16'($urandom));
        6, 7: send_event(MODE_IN_DONE, rt, 8'($urandom), 16'($urandom), 16'($urandom));
        8: send_event(MODE_OUT_DONE, rt, 8'($urandom), 16'($urandom), 16'($urandom));
        9: send_event(MODE_SETUP, rt, REQ_SET_CONFIG, 16'($urandom), 16'($urandom));
        10: send_event(MODE_SETUP, RTYPE_CLASS_IFACE, REQ_SET_IDLE, 16'($urandom),
                       16'($urandom));
        11: send_event(MODE_BUS_RESET, rt, 8'($urandom), 16'($urandom), 16'($urandom));
        default: send_event(mode_t'($urandom_range(0, 3)), rt, 8'($urandom),
                            16'($urandom), 16'($urandom));
      endcase
    end
  endtask

  // ---------------- result side ----------------

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    reply_t exp;
    if (!rst && out_valid && out_ready) begin
      if (expected_replies.size() == 0) begin
        error_count <= error_count + 1;
        if (error_count < 10)
          $display("unexpected reply: kind=%0d byte=%02h last=%0b addr=%0d cfg=%0b",
                   reply_kind, data_byte, last, device_address, configured);
      end else begin
        exp = expected_replies.pop_front();
        if (reply_kind !== exp.kind || data_byte !== exp.data || last !== exp.last ||
            device_address !== exp.addr || configured !== exp.armed) begin
          error_count <= error_count + 1;
          if (error_count < 10)
            $display("reply mismatch: expected kind=%0d byte=%02h last=%0b addr=%0d cfg=%0b, %s",
                     exp.kind, exp.data, exp.last, exp.addr, exp.armed,
                     $sformatf("got kind=%0d byte=%02h last=%0b addr=%0d cfg=%0b",
                               reply_kind, data_byte, last, device_address, configured));
        end
      end
    end
  end

  // ---------------- sequence ----------------

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 31;
    recv_idle_pct = 74;
    test_descriptor_reads();
    test_address_and_config();
    test_random_traffic(70);

    send_idle_pct = 74;
    recv_idle_pct = 31;
    test_random_traffic(70);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(60);

    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("[usb_hid_control_request_responder] OK");
    else
      $display("[usb_hid_control_request_responder] ERROR");
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
sv/usb_hid_pkg.sv
sv/usb_hid_decode.sv
sv/usb_hid_control_request_responder.sv
sv/usb_hid_checker.sv
tb/usb_hid_control_request_responder_tb.sv
